### rtl/hbbc_pkg.sv
// shared constants and types for the hashed block buffer cache
package hbbc_pkg;

  localparam int unsigned NumBuffersDef = 32;
  localparam int unsigned NumBucketsDef = 13;

  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdPin     = 2'd2;
  localparam logic [1:0] CmdUnpin   = 2'd3;

  localparam logic [2:0] StHit      = 3'd0;
  localparam logic [2:0] StMiss     = 3'd1;
  localparam logic [2:0] StNoFree   = 3'd2;
  localparam logic [2:0] StCountOk  = 3'd3;
  localparam logic [2:0] StCountErr = 3'd4;

  localparam logic [7:0] RefsMax = 8'hff;

  // one table entry as stored in memory
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
    logic        valid;
    logic [7:0]  refs;
    logic [31:0] last_use;
    logic [3:0]  bucket;
    logic [31:0] join_order;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### rtl/hashed_block_buffer_cache.sv
// hashed block buffer cache: get scan of all entries, count commands read-modify-write.
// a get folds the block number into a bucket and runs a hit scan; on a miss it runs free
// scans (own bucket, then other buckets) and, once an entry is found, a read and write;
// a hit goes straight to the read and write. release/pin/unpin read and write the entry,
// an out-of-range index is answered from idle. one item at a time, a new transfer is taken
// the cycle after the result transfer. after reset a clearing pass writes initial entries; no input is taken during it.
module hashed_block_buffer_cache
  import hbbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NumBuffersDef,
  parameter int unsigned NUM_BUCKETS = NumBucketsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd[1:0], device[9:2], block_number[41:10], buffer_index[46:42], now_tick[78:47]
  input  logic [79:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], result_index[7:3], needs_read[8]
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(NUM_BUFFERS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HSCAN, S_FSCAN, S_OSCAN, S_RD, S_WR, S_OUT
  } state_e;

  state_e        state_q;
  logic [AW:0]   ptr_q;          // read issue pointer, one beyond depth at end
  logic          rv_q;           // read data for ptr_q-1 is present
  logic [AW-1:0] rptr_q;
  logic [1:0]    cmd_q;
  logic [7:0]    dev_q;
  logic [31:0]   blk_q;
  logic [4:0]    idx_q;
  logic [31:0]   now_q;
  logic [3:0]    bk_q;
  logic [31:0]   jc_q;
  logic          bf_q;           // best found
  logic [AW-1:0] be_q;
  logic [31:0]   blu_q, bage_q;
  logic [3:0]    obk_q;          // best other bucket
  logic [3:0]    rbk_q;
  logic          move_q;
  logic [2:0]    st_q;
  logic          rd_q;
  logic          ov_q;
  logic [8:0]    res_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          hdone;
  logic [3:0]    hbk;
  logic [79:0]   din;
  logic [31:0]   age;
  logic          cnt_err;

  hbbc_ram #(.Width(EntryW), .Depth(NUM_BUFFERS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  hbbc_mod13 #(.NumBuckets(NUM_BUCKETS)) u_mod (
    .clk_i, .rst_ni, .start_i(s_axis_tvalid_i && s_axis_tready_o && din[1:0] == CmdGet),
    .value_i(din[41:10]), .done_o(hdone), .bucket_o(hbk)
  );

  assign din = s_axis_tdata_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {7'd0, res_q};
  assign age = jc_q - rdata.join_order;
  assign raddr = (state_q == S_RD || state_q == S_IDLE) ? idx_q[AW-1:0] : ptr_q[AW-1:0];

  // count limit reached on the entry read back in S_WR
  assign cnt_err = (cmd_q == CmdGet) ? (st_q == StHit && rdata.refs >= RefsMax) :
                   ((cmd_q == CmdPin) ? (rdata.refs >= RefsMax) : (rdata.refs == 8'd0));

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = be_q;
    wdata = rdata;
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = ptr_q[AW-1:0];
      wdata = '0;
      wdata.join_order = 32'(ptr_q[AW-1:0]);
    end else if (state_q == S_WR && rv_q) begin
      we = !cnt_err;
      if (cmd_q == CmdGet) begin
        waddr = be_q;
        wdata.last_use = now_q;
        wdata.valid = 1'b1;
        if (st_q == StHit) begin
          wdata.refs = rdata.refs + 8'd1;
        end else begin
          wdata.refs = 8'd1;
          wdata.device = dev_q;
          wdata.block = blk_q;
          if (move_q) begin
            wdata.bucket = bk_q;
            wdata.join_order = jc_q;
          end
        end
      end else begin
        waddr = idx_q[AW-1:0];
        wdata.refs = (cmd_q == CmdPin) ? rdata.refs + 8'd1 : rdata.refs - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
      jc_q    <= 32'(NUM_BUFFERS);
      bf_q    <= 1'b0;
      move_q  <= 1'b0;
    end else begin
      if (ov_q && m_axis_tready_i) ov_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + (AW+1)'(1);
          if (ptr_q == (AW+1)'(NUM_BUFFERS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            cmd_q <= din[1:0];
            dev_q <= din[9:2];
            blk_q <= din[41:10];
            idx_q <= din[46:42];
            now_q <= din[78:47];
            bf_q  <= 1'b0;
            move_q <= 1'b0;
            ptr_q <= '0;
            rv_q  <= 1'b0;
            if (din[1:0] == CmdGet) begin
              state_q <= S_HASH;
            end else if (32'(din[46:42]) >= 32'(NUM_BUFFERS)) begin
              res_q <= {1'b0, din[46:42], StCountErr};
              ov_q  <= 1'b1;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_HASH: begin
          if (hdone) begin
            bk_q <= hbk;
            state_q <= S_HSCAN;
          end
        end
        S_HSCAN, S_FSCAN, S_OSCAN: begin
          if (ptr_q != (AW+1)'(NUM_BUFFERS)) ptr_q <= ptr_q + (AW+1)'(1);
          rv_q   <= (ptr_q != (AW+1)'(NUM_BUFFERS));
          rptr_q <= ptr_q[AW-1:0];
          if (rv_q) begin
            if (state_q == S_HSCAN) begin
              if (rdata.bucket == bk_q && rdata.device == dev_q && rdata.block == blk_q
                  && (!bf_q || age < bage_q)) begin
                bf_q <= 1'b1; be_q <= rptr_q; bage_q <= age;
              end
            end else if (state_q == S_FSCAN) begin
              if (rdata.bucket == bk_q && rdata.refs == 8'd0 && (!bf_q ||
                  rdata.last_use < blu_q || (rdata.last_use == blu_q && age < bage_q))) begin
                bf_q <= 1'b1; be_q <= rptr_q; blu_q <= rdata.last_use; bage_q <= age;
              end
            end else begin
              // lowest other bucket wins, then lru within it
              if (rdata.bucket != bk_q && rdata.refs == 8'd0 &&
                  32'(rdata.bucket) < 32'(NUM_BUCKETS) && (!bf_q ||
                  rdata.bucket < obk_q || (rdata.bucket == obk_q &&
                  (rdata.last_use < blu_q || (rdata.last_use == blu_q && age < bage_q))))) begin
                bf_q <= 1'b1; be_q <= rptr_q; blu_q <= rdata.last_use;
                bage_q <= age; obk_q <= rdata.bucket;
              end
            end
          end
          if (!rv_q && ptr_q == (AW+1)'(NUM_BUFFERS)) begin
            ptr_q <= '0;
            if (state_q == S_HSCAN) begin
              if (bf_q) begin
                st_q <= StHit; state_q <= S_RD; idx_q <= 5'(be_q);
              end else state_q <= S_FSCAN;
            end else if (state_q == S_FSCAN) begin
              if (bf_q) begin
                st_q <= StMiss; state_q <= S_RD; idx_q <= 5'(be_q);
              end else state_q <= S_OSCAN;
            end else begin
              if (bf_q) begin
                st_q <= StMiss; move_q <= 1'b1; state_q <= S_RD; idx_q <= 5'(be_q);
              end else begin
                res_q <= {1'b0, 5'd0, StNoFree};
                ov_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_RD: begin
          rv_q <= 1'b1;
          state_q <= S_WR;
        end
        S_WR: begin
          rv_q <= 1'b0;
          state_q <= S_IDLE;
          ov_q <= 1'b1;
          if (cmd_q == CmdGet) begin
            if (st_q == StHit) begin
              if (rdata.refs >= RefsMax) res_q <= {1'b0, idx_q, StCountErr};
              else res_q <= {!rdata.valid, idx_q, StHit};
              st_q <= (rdata.refs >= RefsMax) ? StCountErr : StHit;
            end else begin
              res_q <= {1'b1, idx_q, StMiss};
              if (move_q) jc_q <= jc_q + 32'd1;
            end
          end else begin
            if ((cmd_q == CmdPin && rdata.refs >= RefsMax) ||
                (cmd_q != CmdPin && rdata.refs == 8'd0)) begin
              res_q <= {1'b0, idx_q, StCountErr};
              st_q <= StCountErr;
            end else begin
              res_q <= {1'b0, idx_q, StCountOk};
              st_q <= StCountOk;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o)) else $error("result changed");
  a_wr_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |=> (state_q == S_IDLE && m_axis_tvalid_o)) else $error("no result");

endmodule

### rtl/hbbc_ram.sv
// generic simple dual-port synchronous ram with registered read
module hbbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/hbbc_mod13.sv
// block number to bucket, one 4-bit digit folded per cycle
module hbbc_mod13
  import hbbc_pkg::*;
#(
  parameter int unsigned NumBuckets = NumBucketsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [3:0]  bucket_o
);

  logic [31:0] sh_q, sh_d;
  logic [3:0]  rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [8:0]  acc;
  logic [8:0]  red;

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    acc    = {1'b0, rem_q, sh_q[31:28]};
    // acc stays below 16 * NumBuckets, so four restoring steps reduce it fully
    red    = acc;
    if (red >= 9'(NumBuckets * 8)) red = red - 9'(NumBuckets * 8);
    if (red >= 9'(NumBuckets * 4)) red = red - 9'(NumBuckets * 4);
    if (red >= 9'(NumBuckets * 2)) red = red - 9'(NumBuckets * 2);
    if (red >= 9'(NumBuckets))     red = red - 9'(NumBuckets);
    if (start_i) begin
      sh_d   = value_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = red[3:0];
      sh_d   = {sh_q[27:0], 4'h0};
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'd7) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      sh_q   <= sh_d;
    end
  end

  assign done_o   = busy_q && (cnt_q == 4'd7);
  assign bucket_o = rem_d;

endmodule
